// ----- rtl/core/gmbi_pkg.sv -----
// gmbi_pkg: shared constants, types and codes for the grid map interpolator
// used by every file under rtl/core; no dependencies of its own

package gmbi_pkg;

  // grid geometry and coordinate format
  localparam int ROWS      = 128;
  localparam int COLS      = 128;
  localparam int FRAC_BITS = 8;

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int DEPTH  = ROWS * COLS;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam int DATA_W = 16;
  localparam int SCALE  = 1 << FRAC_BITS;
  localparam int W_W    = FRAC_BITS + 1;       // one axis weight, up to SCALE
  localparam int WGT_W  = 2 * FRAC_BITS + 1;   // corner weight, up to SCALE^2
  localparam int ACC_W  = 2 * FRAC_BITS + 18;  // weighted sum of four corners

  localparam logic [DATA_W-1:0] ONE_Q15 = 16'd32768;

  // request codes carried in in_tuser
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic                 clr;
    logic                 load_w;
    logic [1:0]           corner;
    logic [FRAC_BITS-1:0] fr;
    logic [FRAC_BITS-1:0] fc;
  } mac_ctl_t;

endpackage

// ----- rtl/core/gmbi_table.sv -----
// gmbi_table: single-port synchronous grid table with a registered read port
// depends on gmbi_pkg

module gmbi_table (
  input  logic                          clk,
  input  gmbi_pkg::mem_req_t            req,
  output logic [gmbi_pkg::DATA_W-1:0]   rdata
);

  logic [gmbi_pkg::DATA_W-1:0] mem [gmbi_pkg::DEPTH];
  logic [gmbi_pkg::DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/gmbi_mac.sv -----
// gmbi_mac: corner weight generation and weighted accumulation of table reads
// depends on gmbi_pkg

module gmbi_mac (
  input  logic                          clk,
  input  gmbi_pkg::mac_ctl_t            ctl,
  input  logic [gmbi_pkg::DATA_W-1:0]   rdata,
  output logic [gmbi_pkg::DATA_W-1:0]   value
);

  logic [gmbi_pkg::W_W-1:0]   wr;
  logic [gmbi_pkg::W_W-1:0]   wc;
  logic [gmbi_pkg::WGT_W-1:0] wgt_nxt;
  logic [gmbi_pkg::WGT_W-1:0] wgt_r;
  logic [gmbi_pkg::ACC_W-1:0] prod;
  logic [gmbi_pkg::ACC_W-1:0] acc_r;
  logic                       acc_en_r;

  // corner bit 1 selects the lower row, bit 0 the right column
  always_comb begin
    wr = ctl.corner[1] ? gmbi_pkg::W_W'(ctl.fr)
                       : gmbi_pkg::W_W'(gmbi_pkg::SCALE) - gmbi_pkg::W_W'(ctl.fr);
    wc = ctl.corner[0] ? gmbi_pkg::W_W'(ctl.fc)
                       : gmbi_pkg::W_W'(gmbi_pkg::SCALE) - gmbi_pkg::W_W'(ctl.fc);
    wgt_nxt = gmbi_pkg::WGT_W'(wr) * gmbi_pkg::WGT_W'(wc);
    prod    = gmbi_pkg::ACC_W'(wgt_r) * gmbi_pkg::ACC_W'(rdata);
  end

  // weight is registered with the read, product lands as the data returns
  always_ff @(posedge clk) begin
    acc_en_r <= ctl.load_w;
    if (ctl.load_w) begin
      wgt_r <= wgt_nxt;
    end
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (acc_en_r) begin
      acc_r <= acc_r + prod;
    end
  end

  assign value = acc_r[2*gmbi_pkg::FRAC_BITS +: gmbi_pkg::DATA_W];

endmodule

// ----- rtl/core/gmbi_ctrl.sv -----
// gmbi_ctrl: request decode, clearing sweep, corner sequencing and output register
// depends on gmbi_pkg

module gmbi_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [63:0]                   in_tdata,
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [15:0]                   out_tdata,
  output logic                          out_tuser,
  output gmbi_pkg::mem_req_t            mem_req,
  output gmbi_pkg::mac_ctl_t            mac_ctl,
  input  logic [gmbi_pkg::DATA_W-1:0]   mac_value
);

  gmbi_pkg::state_t state_r, state_nxt;

  logic [gmbi_pkg::ADDR_W-1:0]    clr_addr_r;
  logic [1:0]                     k_r;
  logic [gmbi_pkg::ROW_W-1:0]     row_r;
  logic [gmbi_pkg::COL_W-1:0]     col_r;
  logic [gmbi_pkg::FRAC_BITS-1:0] fr_r;
  logic [gmbi_pkg::FRAC_BITS-1:0] fc_r;
  logic                           hit_r;
  logic                           out_valid_r;
  logic [gmbi_pkg::DATA_W-1:0]    out_value_r;
  logic                           out_hit_r;

  logic [6:0]  write_row;
  logic [6:0]  write_col;
  logic [15:0] write_value;
  logic [15:0] row_coord;
  logic [15:0] col_coord;

  logic        in_fire;
  logic        wr_inside;
  logic        rd_inside;
  logic [16:0] ri_ext;
  logic [16:0] ci_ext;
  logic [15:0] wval_sat;
  logic [gmbi_pkg::ROW_W-1:0]  crow;
  logic [gmbi_pkg::COL_W-1:0]  ccol;
  logic [gmbi_pkg::ADDR_W-1:0] rd_addr;
  logic [gmbi_pkg::ADDR_W-1:0] wr_addr;
  logic        out_free;

  assign write_row   = in_tdata[6:0];
  assign write_col   = in_tdata[13:7];
  assign write_value = in_tdata[29:14];
  assign row_coord   = in_tdata[45:30];
  assign col_coord   = in_tdata[61:46];

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    ri_ext    = 17'(row_coord[14:gmbi_pkg::FRAC_BITS]);
    ci_ext    = 17'(col_coord[14:gmbi_pkg::FRAC_BITS]);
    // negative coordinates count as outside the grid
    rd_inside = !row_coord[15] && !col_coord[15]
                && (ri_ext + 17'd1 < 17'(gmbi_pkg::ROWS))
                && (ci_ext + 17'd1 < 17'(gmbi_pkg::COLS));
    wr_inside = (9'(write_row) < 9'(gmbi_pkg::ROWS))
                && (9'(write_col) < 9'(gmbi_pkg::COLS));
    wval_sat  = (write_value > gmbi_pkg::ONE_Q15) ? gmbi_pkg::ONE_Q15 : write_value;
    wr_addr   = gmbi_pkg::ADDR_W'(write_row) * gmbi_pkg::ADDR_W'(gmbi_pkg::COLS)
                + gmbi_pkg::ADDR_W'(write_col);
    crow      = row_r + gmbi_pkg::ROW_W'(k_r[1]);
    ccol      = col_r + gmbi_pkg::COL_W'(k_r[0]);
    rd_addr   = gmbi_pkg::ADDR_W'(crow) * gmbi_pkg::ADDR_W'(gmbi_pkg::COLS)
                + gmbi_pkg::ADDR_W'(ccol);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gmbi_pkg::ST_CLEAR: begin
        if (clr_addr_r == gmbi_pkg::ADDR_W'(gmbi_pkg::DEPTH - 1)) begin
          state_nxt = gmbi_pkg::ST_IDLE;
        end
      end
      gmbi_pkg::ST_IDLE: begin
        if (in_fire && in_tuser == gmbi_pkg::MODE_LOOKUP) begin
          state_nxt = rd_inside ? gmbi_pkg::ST_READ : gmbi_pkg::ST_DONE;
        end
      end
      gmbi_pkg::ST_READ: begin
        if (k_r == 2'd3) begin
          state_nxt = gmbi_pkg::ST_ACC;
        end
      end
      gmbi_pkg::ST_ACC: begin
        state_nxt = gmbi_pkg::ST_DONE;
      end
      gmbi_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = gmbi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = gmbi_pkg::ST_CLEAR;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_tready      = 1'b0;
    mem_req        = '0;
    mac_ctl.clr    = 1'b0;
    mac_ctl.load_w = 1'b0;
    mac_ctl.corner = k_r;
    mac_ctl.fr     = fr_r;
    mac_ctl.fc     = fc_r;
    case (state_r)
      gmbi_pkg::ST_CLEAR: begin
        mem_req.we   = 1'b1;
        mem_req.addr = clr_addr_r;
      end
      gmbi_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && in_tuser == gmbi_pkg::MODE_WRITE && wr_inside) begin
          mem_req.we    = 1'b1;
          mem_req.addr  = wr_addr;
          mem_req.wdata = wval_sat;
        end
        if (in_tvalid && in_tuser == gmbi_pkg::MODE_LOOKUP) begin
          mac_ctl.clr = 1'b1;
        end
      end
      gmbi_pkg::ST_READ: begin
        mem_req.re     = 1'b1;
        mem_req.addr   = rd_addr;
        mac_ctl.load_w = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gmbi_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == gmbi_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + gmbi_pkg::ADDR_W'(1);
      end
      if (state_r == gmbi_pkg::ST_READ) begin
        k_r <= k_r + 2'd1;
      end else begin
        k_r <= '0;
      end
      if (state_r == gmbi_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_tuser == gmbi_pkg::MODE_LOOKUP) begin
      row_r <= gmbi_pkg::ROW_W'(ri_ext);
      col_r <= gmbi_pkg::COL_W'(ci_ext);
      fr_r  <= row_coord[gmbi_pkg::FRAC_BITS-1:0];
      fc_r  <= col_coord[gmbi_pkg::FRAC_BITS-1:0];
      hit_r <= rd_inside;
    end
    if (state_r == gmbi_pkg::ST_DONE && out_free) begin
      out_value_r <= mac_value;
      out_hit_r   <= hit_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_hit_r;

endmodule

// ----- rtl/core/grid_map_bilinear_interpolator.sv -----
// grid_map_bilinear_interpolator: top level of the bilinear grid map lookup
// depends on gmbi_pkg, gmbi_table, gmbi_mac and gmbi_ctrl
//
// usage:
//   in_* carries requests; in_tuser is the mode (0 write entry, 1 lookup).
//   a write stores min(write_value, 1.0) at (write_row, write_col) when that
//   cell lies in the grid, and produces no result.
//   a lookup blends the four table entries around (row_coord, col_coord),
//   signed Q7.8, and returns one result on out_*: out_tdata is the Q1.15
//   value, out_tuser the hit flag (clear and value zero outside the grid).
//   a lookup inside the grid steps through READ (one table read per corner),
//   ACC and DONE, and one outside it goes straight to DONE; the result is
//   registered as DONE is left, once the output register is free, and the
//   next request is taken back in IDLE; the four corner reads share the
//   single table port.
//   after reset the table is swept to zero, one entry per cycle, over every
//   entry, with in_tready low for the whole sweep.
//   a result waiting in the output register does not block new requests;
//   a finished lookup holds in its last state while an earlier result sits
//   unaccepted in the output register.

module grid_map_bilinear_interpolator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // write_row, write_col, write_value, row_coord, col_coord
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // value
  output logic        out_tuser   // hit
);

  gmbi_pkg::mem_req_t          mem_req;
  gmbi_pkg::mac_ctl_t          mac_ctl;
  logic [gmbi_pkg::DATA_W-1:0] rdata;
  logic [gmbi_pkg::DATA_W-1:0] mac_value;

  gmbi_table u_table (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  gmbi_mac u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .rdata (rdata),
    .value (mac_value)
  );

  gmbi_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mem_req    (mem_req),
    .mac_ctl    (mac_ctl),
    .mac_value  (mac_value)
  );

endmodule

// ----- rtl/core/gmbi_checker.sv -----
// gmbi_checker: port-level assertions for grid_map_bilinear_interpolator
// depends on gmbi_pkg; bound to the top level below

module gmbi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // table sweep keeps requests out right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("request taken during table sweep");

  // a lookup keeps the block busy, with in_tready low, until it is back in idle
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == gmbi_pkg::MODE_LOOKUP |=> !in_tready)
    else $error("request taken right after a lookup");

  // a miss always reports zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss with nonzero value");

  // blend never exceeds the largest stored entry, itself at most 1.0
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= gmbi_pkg::ONE_Q15)
    else $error("value above 1.0");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind grid_map_bilinear_interpolator gmbi_checker u_gmbi_checker (.*);
